[sv/rbmd_pkg.sv]
`default_nettype none
package rbmd_pkg;

  localparam int BLOCK_LEN  = 4;
  localparam int MAX_BLOCKS = 256;
  localparam int WORD_W     = BLOCK_LEN * 8;
  localparam int POS_W      = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int FILL_W     = $clog2(BLOCK_LEN + 1);
  localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NBLK_W     = $clog2(MAX_BLOCKS + 1);

  typedef enum logic {
    CMD_OLD = 1'b0,
    CMD_NEW = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       data;
    logic             eof;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_HIT,
    ST_MISS,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

[sv/rolling_block_match_delta_top.sv]
// Old-file word: held in the input queue, then taken by the back engine into the
// block being assembled. New-file word: appended to the window; a full window then
// scans the stored blocks, each block with one memory read and one compare, and the
// bytes left in the window are flushed as literals at end of file.
// Results are registered; the output holds until popped.
// Synchronous active-low reset empties the window, block store and queues.
`default_nettype none
module rolling_block_match_delta_top import rbmd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_file,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_token_kind,
  output logic [7:0]      out_literal_value,
  output logic [7:0]      out_block_index,
  output logic            out_final_token
);

  logic cmd_valid, cmd_pop, out_valid;
  cmd_t cmd;

  rbmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .kind        (in_kind),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  rbmd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_pop       (out_pop),
    .token_kind    (out_token_kind),
    .literal_value (out_literal_value),
    .block_index   (out_block_index),
    .final_token   (out_final_token)
  );

  assign out_empty = !out_valid;

endmodule
`default_nettype wire

[sv/rbmd_front.sv]
`default_nettype none
module rbmd_front import rbmd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_file,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);

  cmd_t               q_r [2];
  logic               wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [NBLK_W-1:0]  blk_r, blk_nxt;
  logic               acc, enq, deq, store_full;
  cmd_t               cmd_in;

  assign full       = (cnt_r == 2'd2);
  assign cmd_valid  = (cnt_r != 2'd0);
  assign cmd        = q_r[rd_r];
  assign acc        = push && !full;
  assign store_full = (blk_r == NBLK_W'(MAX_BLOCKS));
  // old bytes past the store capacity are dropped here
  assign enq        = acc && (kind || !store_full);
  assign deq        = cmd_pop && cmd_valid;

  always_comb begin
    cmd_in.op   = kind ? CMD_NEW : CMD_OLD;
    cmd_in.data = data_byte;
    cmd_in.eof  = kind && end_of_file;
    cmd_in.pos  = pos_r;
    pos_nxt = pos_r;
    blk_nxt = blk_r;
    if (acc && !kind && !store_full) begin
      if (pos_r == POS_W'(BLOCK_LEN - 1)) begin
        pos_nxt = '0;
        blk_nxt = blk_r + 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
    wr_nxt  = enq ? !wr_r : wr_r;
    rd_nxt  = deq ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
      pos_r <= '0;
      blk_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      blk_r <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q_r[wr_r] <= cmd_in;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
    blk_r <= NBLK_W'(MAX_BLOCKS)) else $error("block count overrun");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_r == rd_r) else $error("pointer mismatch");

endmodule
`default_nettype wire

[sv/rbmd_back.sv]
`default_nettype none
module rbmd_back import rbmd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  wire logic       out_pop,
  output logic            token_kind,
  output logic [7:0]      literal_value,
  output logic [7:0]      block_index,
  output logic            final_token
);

  logic [WORD_W-1:0] mem [MAX_BLOCKS];
  logic [WORD_W-1:0] rdata_r;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [WORD_W-1:0] win_r, win_nxt, part_r, part_nxt;
  logic              eof_r, eof_nxt;
  logic [NBLK_W-1:0] scan_r, scan_nxt, nblk_r, nblk_nxt;
  logic              ov_r, ov_nxt, ok_r, ok_nxt, ofin_r, ofin_nxt;
  logic [7:0]        olit_r, olit_nxt, oidx_r, oidx_nxt;
  logic              slot_free, mem_we, take_new, take_old;

  assign slot_free     = !ov_r || out_pop;
  assign cmd_pop       = (state_r == ST_IDLE) && cmd_valid;
  assign take_new      = cmd_pop && (cmd.op == CMD_NEW);
  assign take_old      = cmd_pop && (cmd.op == CMD_OLD);
  assign mem_we        = take_old && (cmd.pos == POS_W'(BLOCK_LEN - 1));
  assign out_valid     = ov_r;
  assign token_kind    = ok_r;
  assign literal_value = olit_r;
  assign block_index   = oidx_r;
  assign final_token   = ofin_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take_new) begin
          if (fill_r == FILL_W'(BLOCK_LEN - 1)) state_nxt = ST_SCAN_RD;
          else if (cmd.eof)                     state_nxt = ST_FLUSH;
        end
      end
      ST_SCAN_RD:  state_nxt = (scan_r == nblk_r) ? ST_MISS : ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = (rdata_r == win_r) ? ST_HIT : ST_SCAN_RD;
      ST_HIT:      if (slot_free) state_nxt = ST_IDLE;
      ST_MISS:     if (slot_free) state_nxt = eof_r ? ST_FLUSH : ST_IDLE;
      ST_FLUSH:    if (slot_free && fill_r == FILL_W'(1)) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    win_nxt  = win_r;
    part_nxt = part_r;
    eof_nxt  = eof_r;
    scan_nxt = scan_r;
    nblk_nxt = nblk_r;
    ov_nxt   = ov_r && !out_pop;
    ok_nxt   = ok_r;
    olit_nxt = olit_r;
    oidx_nxt = oidx_r;
    ofin_nxt = ofin_r;
    case (state_r)
      ST_IDLE: begin
        if (take_old) begin
          for (int k = 0; k < BLOCK_LEN; k++) begin
            if (cmd.pos == POS_W'(k)) part_nxt[k*8 +: 8] = cmd.data;
          end
          if (mem_we) nblk_nxt = nblk_r + 1'b1;
        end
        if (take_new) begin
          for (int k = 0; k < BLOCK_LEN; k++) begin
            if (fill_r == FILL_W'(k)) win_nxt[k*8 +: 8] = cmd.data;
          end
          fill_nxt = fill_r + 1'b1;
          eof_nxt  = cmd.eof;
          scan_nxt = '0;
        end
      end
      ST_SCAN_CMP: begin
        if (rdata_r != win_r) scan_nxt = scan_r + 1'b1;
      end
      ST_HIT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b1;
          olit_nxt = '0;
          oidx_nxt = 8'(scan_r);
          ofin_nxt = eof_r;
          fill_nxt = '0;
        end
      end
      ST_MISS, ST_FLUSH: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b0;
          olit_nxt = win_r[7:0];
          oidx_nxt = '0;
          ofin_nxt = (state_r == ST_FLUSH) && (fill_r == FILL_W'(1));
          win_nxt  = win_r >> 8;
          fill_nxt = fill_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      eof_r   <= 1'b0;
      scan_r  <= '0;
      nblk_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      eof_r   <= eof_nxt;
      scan_r  <= scan_nxt;
      nblk_r  <= nblk_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    part_r <= part_nxt;
    ok_r   <= ok_nxt;
    olit_r <= olit_nxt;
    oidx_r <= oidx_nxt;
    ofin_r <= ofin_nxt;
  end

  // block store: one word per block, byte k in lane k
  always_ff @(posedge clk) begin
    if (mem_we) mem[nblk_r[BLK_W-1:0]] <= part_nxt;
    rdata_r <= mem[scan_r[BLK_W-1:0]];
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BLOCK_LEN)) else $error("window overfill");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN_CMP |-> scan_r < nblk_r) else $error("scan past stored blocks");
  a_full_win: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HIT || state_r == ST_MISS) |-> fill_r == FILL_W'(BLOCK_LEN))
    else $error("match step without full window");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_pop |=> ov_r && $stable(olit_r) && $stable(oidx_r))
    else $error("word lost");

endmodule
`default_nettype wire
